// ===== design/tkss_pkg.sv =====
// Shared types, constants and the ranking function for the top-k score selector.
// Used by tkss_ctrl, tkss_datapath and top_k_score_selector_unit.
package tkss_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int KEEP_W   = 5;
    localparam int CMP_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int DOC_W    = 31;
    localparam int SCORE_W  = 32;
    localparam int RANK_W   = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // capture the incoming pair for a replace search
        logic append;       // store the incoming pair at the fill level
        logic scan_clr;     // restart the entry scan
        logic scan_ins;     // one scan step looking for the worst entry
        logic scan_drn;     // one scan step looking for the best unsent entry
        logic ins_write;    // replace the worst entry if the new pair beats it
        logic drain_start;  // latch the result count, clear sent marks
        logic push;         // load the output register
        logic clear_count;  // empty the store
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic keep_zero;
        logic has_room;
        logic drain_empty;
        logic scan_last;
        logic push_last;
        logic out_free;
    } t_dp_stat;

    // True when pair a ranks strictly above pair b.
    function automatic logic better(
        input logic        [DOC_W-1:0]   doc_a,
        input logic signed [SCORE_W-1:0] score_a,
        input logic        [DOC_W-1:0]   doc_b,
        input logic signed [SCORE_W-1:0] score_b
    );
        logic res;
        if (score_a != score_b) begin
            res = (score_a > score_b);
        end else begin
            res = (doc_a < doc_b);
        end
        return res;
    endfunction

endpackage

// ===== design/tkss_ctrl.sv =====
// Sequencing state machine for the top-k score selector.
// Depends on tkss_pkg; drives tkss_datapath through t_dp_cmd.
module tkss_ctrl import tkss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_WRITE,
        S_DRN_SCAN,
        S_DRN_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_DRAIN) begin
                        o_cmd.drain_start = 1'b1;
                        o_cmd.scan_clr    = 1'b1;
                        n_state = i_stat.drain_empty ? S_DRN_PUSH : S_DRN_SCAN;
                    end else if (!i_stat.keep_zero) begin
                        if (i_stat.has_room) begin
                            o_cmd.append = 1'b1;
                        end else begin
                            o_cmd.load_in  = 1'b1;
                            o_cmd.scan_clr = 1'b1;
                            n_state = S_INS_SCAN;
                        end
                    end
                end
            end
            S_INS_SCAN: begin
                o_cmd.scan_ins = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                o_cmd.ins_write = 1'b1;
                n_state = S_IDLE;
            end
            S_DRN_SCAN: begin
                o_cmd.scan_drn = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRN_PUSH;
                end
            end
            S_DRN_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_stat.push_last) begin
                        o_cmd.clear_count = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_DRN_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/tkss_datapath.sv =====
// Entry store, scan unit and output register of the top-k score selector.
// Depends on tkss_pkg; commanded by tkss_ctrl.
module tkss_datapath import tkss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic        [KEEP_W-1:0]  i_cfg_data,
    input  logic        [DOC_W-1:0]   i_doc_id,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic                      i_out_stall,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_out_valid,
    output logic        [DOC_W-1:0]   o_out_doc_id,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic        [RANK_W-1:0]  o_rank,
    output logic                      o_valid_res,
    output logic                      o_last
);

    logic        [KEEP_W-1:0]   r_keep;
    logic        [CNT_W-1:0]    r_count;
    logic        [DOC_W-1:0]    r_doc   [MAX_KEEP];
    logic signed [SCORE_W-1:0]  r_score [MAX_KEEP];
    logic        [MAX_KEEP-1:0] r_done;
    logic        [IDX_W-1:0]    r_idx;
    logic                       r_cand_ok;
    logic        [IDX_W-1:0]    r_cand_idx;
    logic        [DOC_W-1:0]    r_cand_doc;
    logic signed [SCORE_W-1:0]  r_cand_score;
    logic        [DOC_W-1:0]    r_new_doc;
    logic signed [SCORE_W-1:0]  r_new_score;
    logic        [CNT_W-1:0]    r_emit;
    logic        [CNT_W-1:0]    r_rank;
    logic                       r_out_valid;
    logic        [DOC_W-1:0]    r_out_doc;
    logic signed [SCORE_W-1:0]  r_out_score;
    logic        [RANK_W-1:0]   r_out_rank;
    logic                       r_out_res;
    logic                       r_out_last;

    logic        [CMP_W-1:0]    w_keep_eff;
    logic        [CMP_W-1:0]    w_count_wide;
    logic        [CNT_W-1:0]    w_emit_now;
    logic        [DOC_W-1:0]    w_rd_doc;
    logic signed [SCORE_W-1:0]  w_rd_score;
    logic                       w_take_ins;
    logic                       w_take_drn;
    logic                       w_take;
    logic                       w_new_wins;
    logic        [CNT_W-1:0]    w_rank_next;

    // Saturate the keep count at the store depth.
    assign w_keep_eff   = (CMP_W'(r_keep) > CMP_W'(MAX_KEEP)) ? CMP_W'(MAX_KEEP)
                                                              : CMP_W'(r_keep);
    assign w_count_wide = CMP_W'(r_count);
    assign w_emit_now   = (w_count_wide < w_keep_eff) ? r_count : CNT_W'(w_keep_eff);

    assign w_rd_doc   = r_doc[r_idx];
    assign w_rd_score = r_score[r_idx];

    // Worst-entry search keeps the earlier of two identical pairs.
    assign w_take_ins = !r_cand_ok ||
                        better(r_cand_doc, r_cand_score, w_rd_doc, w_rd_score);
    assign w_take_drn = !r_done[r_idx] && (!r_cand_ok ||
                        better(w_rd_doc, w_rd_score, r_cand_doc, r_cand_score));
    assign w_take     = (i_cmd.scan_ins && w_take_ins) || (i_cmd.scan_drn && w_take_drn);
    assign w_new_wins = better(r_new_doc, r_new_score, r_cand_doc, r_cand_score);
    assign w_rank_next = r_rank + CNT_W'(1);

    assign o_stat.keep_zero   = (w_keep_eff == '0);
    assign o_stat.has_room    = (w_count_wide < w_keep_eff);
    assign o_stat.drain_empty = (w_emit_now == '0);
    assign o_stat.scan_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_stat.push_last   = (r_emit == '0) || (w_rank_next == r_emit);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= KEEP_RESET;
            r_count     <= '0;
            r_done      <= '0;
            r_idx       <= '0;
            r_cand_ok   <= 1'b0;
            r_emit      <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.clear_count) begin
                r_count <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_idx     <= '0;
                r_cand_ok <= 1'b0;
            end else if (i_cmd.scan_ins || i_cmd.scan_drn) begin
                r_idx <= r_idx + IDX_W'(1);
                if (w_take) begin
                    r_cand_ok <= 1'b1;
                end
            end
            if (i_cmd.drain_start) begin
                r_emit <= w_emit_now;
                r_rank <= '0;
                r_done <= '0;
            end else if (i_cmd.push) begin
                r_rank <= w_rank_next;
                if (r_emit != '0) begin
                    r_done[r_cand_idx] <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_doc[r_count[IDX_W-1:0]]   <= i_doc_id;
            r_score[r_count[IDX_W-1:0]] <= i_score;
        end else if (i_cmd.ins_write && w_new_wins) begin
            r_doc[r_cand_idx]   <= r_new_doc;
            r_score[r_cand_idx] <= r_new_score;
        end
        if (i_cmd.load_in) begin
            r_new_doc   <= i_doc_id;
            r_new_score <= i_score;
        end
        if (w_take) begin
            r_cand_idx   <= r_idx;
            r_cand_doc   <= w_rd_doc;
            r_cand_score <= w_rd_score;
        end
        if (i_cmd.push) begin
            if (r_emit == '0) begin
                r_out_doc   <= '0;
                r_out_score <= '0;
                r_out_rank  <= '0;
                r_out_res   <= 1'b0;
                r_out_last  <= 1'b1;
            end else begin
                r_out_doc   <= r_cand_doc;
                r_out_score <= r_cand_score;
                r_out_rank  <= RANK_W'(w_rank_next);
                r_out_res   <= 1'b1;
                r_out_last  <= o_stat.push_last;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_doc_id = r_out_doc;
    assign o_out_score  = r_out_score;
    assign o_rank       = r_out_rank;
    assign o_valid_res  = r_out_res;
    assign o_last       = r_out_last;

endmodule

// ===== design/top_k_score_selector_unit.sv =====
// Top level of the top-k score selector: controller plus datapath.
// Depends on tkss_pkg, tkss_ctrl and tkss_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per beat:
//   insert (doc_id, score) or drain. Output channel (o_out_valid / i_out_stall)
//   carries ranked results, best first, rank from 1, o_last on the final beat.
//   A drain of an empty store (or with keep count zero) gives one beat with
//   o_valid_res low, rank 0 and o_last high.
//   Configuration: pulse i_cfg_we with i_cfg_data to set the keep count
//   (saturates at 16 entries); write only while the block is idle.
// Steps, with n entries stored:
//   insert below the keep count: appended at once, next beat accepted right after.
//   insert into a full store: the accept, the scan and the write step; the scan
//   walks the entry registers one per cycle to find the worst entry.
//   drain of k results: for each result the scan walks all n entries, then the
//   output register is loaded once it is free; each pass of the single
//   scan unit picks the best entry not yet sent.
// Reset (i_rst_n low, synchronous): store empty, keep count 10, no result.
// When the receiver stalls, hold the result in the output register; a drain
// waits on it before loading the next one. The last result of a drain may
// wait there while new inserts are already being taken.
module top_k_score_selector_unit import tkss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic        [KEEP_W-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic        [DOC_W-1:0]   i_doc_id,
    input  logic signed [SCORE_W-1:0] i_score,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic        [DOC_W-1:0]   o_out_doc_id,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic        [RANK_W-1:0]  o_rank,
    output logic                      o_valid_res,
    output logic                      o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: decides insert/replace/drain steps from datapath status.
    tkss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Entry store, scan unit, keep-count register and output register.
    tkss_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_doc_id     (i_doc_id),
        .i_score      (i_score),
        .i_out_stall  (i_out_stall),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_out_doc_id (o_out_doc_id),
        .o_out_score  (o_out_score),
        .o_rank       (o_rank),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );

    // An empty result is always the sole, last beat of its drain.
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_last && (o_rank == '0)))
        else $error("empty result with rank or without last mark");

    // A carried entry always has a nonzero rank.
    a_rank_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_rank != '0))
        else $error("stored entry sent with rank zero");

    // While a drain still has results to send, no new command is taken.
    a_drain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_in_stall)
        else $error("input accepted in the middle of a drain");

    // Append, replace capture and drain start only fire on an accepted beat.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.append || w_cmd.load_in || w_cmd.drain_start) |-> !o_in_stall)
        else $error("command start issued outside idle");

endmodule

// ===== tb/topk_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the top-k score selector: tracks the kept pairs and the keep count,
// predicts each ranked result beat and compares it with the beat the block emits.
// Depends on tkss_pkg.
module topk_result_checker import tkss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic        [KEEP_W-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_command,
    input  logic        [DOC_W-1:0]   i_doc_id,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic        [DOC_W-1:0]   i_out_doc_id,
    input  logic signed [SCORE_W-1:0] i_out_score,
    input  logic        [RANK_W-1:0]  i_rank,
    input  logic                      i_valid_res,
    input  logic                      i_last,
    output int                        o_pending,
    output int                        o_errors
);

    typedef struct {
        logic        [DOC_W-1:0]   doc;
        logic signed [SCORE_W-1:0] score;
        logic        [RANK_W-1:0]  rank;
        logic                      hit;
        logic                      last;
    } t_ranked_beat;

    logic        [KEEP_W-1:0]  keep_reg;
    logic        [DOC_W-1:0]   kept_doc   [MAX_KEEP];
    logic signed [SCORE_W-1:0] kept_score [MAX_KEEP];
    int                        kept_n;
    t_ranked_beat              ranked_q   [$];

    // Higher key means better pair: offset-binary score on top, inverted doc id below.
    function automatic logic [SCORE_W+DOC_W-1:0] rank_key(
        input logic        [DOC_W-1:0]   doc,
        input logic signed [SCORE_W-1:0] score
    );
        return {~score[SCORE_W-1], score[SCORE_W-2:0], ~doc};
    endfunction

    function automatic int keep_limit();
        return (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
    endfunction

    function automatic void take_insert(
        input logic        [DOC_W-1:0]   doc,
        input logic signed [SCORE_W-1:0] score
    );
        int lim;
        int worst;
        lim = keep_limit();
        if (lim == 0) begin
            return;
        end
        if (kept_n < lim) begin
            kept_doc[kept_n]   = doc;
            kept_score[kept_n] = score;
            kept_n++;
            return;
        end
        worst = 0;
        for (int i = 1; i < kept_n; i++) begin
            if (rank_key(kept_doc[worst], kept_score[worst]) >
                rank_key(kept_doc[i], kept_score[i])) begin
                worst = i;
            end
        end
        if (rank_key(doc, score) > rank_key(kept_doc[worst], kept_score[worst])) begin
            kept_doc[worst]   = doc;
            kept_score[worst] = score;
        end
    endfunction

    function automatic void take_drain();
        logic        [DOC_W-1:0]   d [MAX_KEEP];
        logic signed [SCORE_W-1:0] s [MAX_KEEP];
        logic        [DOC_W-1:0]   td;
        logic signed [SCORE_W-1:0] ts;
        t_ranked_beat              beat;
        int                        n;
        int                        emit;
        int                        b;
        n    = kept_n;
        emit = (n < keep_limit()) ? n : keep_limit();
        for (int i = 0; i < n; i++) begin
            d[i] = kept_doc[i];
            s[i] = kept_score[i];
        end
        kept_n = 0;
        if (emit == 0) begin
            beat.doc   = '0;
            beat.score = '0;
            beat.rank  = '0;
            beat.hit   = 1'b0;
            beat.last  = 1'b1;
            ranked_q.insert(ranked_q.size(), beat);
            return;
        end
        for (int i = 0; i < emit; i++) begin
            b = i;
            for (int j = i + 1; j < n; j++) begin
                if (rank_key(d[j], s[j]) > rank_key(d[b], s[b])) begin
                    b = j;
                end
            end
            td = d[i]; d[i] = d[b]; d[b] = td;
            ts = s[i]; s[i] = s[b]; s[b] = ts;
            beat.doc   = d[i];
            beat.score = s[i];
            beat.rank  = RANK_W'(i + 1);
            beat.hit   = 1'b1;
            beat.last  = (i == emit - 1);
            ranked_q.insert(ranked_q.size(), beat);
        end
    endfunction

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_ranked_beat want;
        if (!i_rst_n) begin
            keep_reg = KEEP_RESET;
            kept_n   = 0;
            ranked_q.delete();
        end else begin
            if (i_cfg_we) begin
                keep_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_DRAIN) begin
                    take_drain();
                end else begin
                    take_insert(i_doc_id, i_score);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (ranked_q.size() == 0) begin
                    $display("%0t ns: unexpected beat, expected none, actual doc %0d score %0d",
                             $time, i_out_doc_id, i_out_score);
                    o_errors++;
                end else begin
                    want = ranked_q.pop_front();
                    check_field("doc_id", want.doc, i_out_doc_id);
                    check_field("score", want.score, i_out_score);
                    check_field("rank", want.rank, i_rank);
                    check_field("valid_res", want.hit, i_valid_res);
                    check_field("last", want.last, i_last);
                end
            end
        end
        o_pending = ranked_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the top-k score selector testbench: clock, reset, keep-count writes, command
// stimulus and result-side stalls. Depends on tkss_pkg, topk_result_checker and the RTL.
module tb_top import tkss_pkg::*; ();

    localparam int ITEM_TARGET   = 480;
    // An insert into a full store scans every entry before it writes.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic        [KEEP_W-1:0]  i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_command;
    logic        [DOC_W-1:0]   i_doc_id;
    logic signed [SCORE_W-1:0] i_score;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic        [DOC_W-1:0]   o_out_doc_id;
    logic signed [SCORE_W-1:0] o_out_score;
    logic        [RANK_W-1:0]  o_rank;
    logic                      o_valid_res;
    logic                      o_last;

    int                        pending;
    int                        errors;
    int                        items_sent;
    int                        cur_keep;
    bit                        in_calm;
    bit                        out_calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    top_k_score_selector_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_doc_id     (i_doc_id),
        .i_score      (i_score),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_doc_id (o_out_doc_id),
        .o_out_score  (o_out_score),
        .o_rank       (o_rank),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );

    // The checker sees both channels and the register port exactly as the block does.
    topk_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_doc_id     (i_doc_id),
        .i_score      (i_score),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_doc_id (o_out_doc_id),
        .i_out_score  (o_out_score),
        .i_rank       (o_rank),
        .i_valid_res  (o_valid_res),
        .i_last       (o_last),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    // Effective keep count as the block sees it: writes above 16 saturate.
    function automatic int eff_keep();
        return (cur_keep > MAX_KEEP) ? MAX_KEEP : cur_keep;
    endfunction

    // Mostly back to back, some short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (in_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Small ids collide often, which exercises the tie-break and identical pairs.
    function automatic logic [DOC_W-1:0] pick_doc();
        case ($urandom_range(0, 3))
            0: begin
                return DOC_W'($urandom_range(0, 7));
            end
            1: begin
                return ($urandom_range(0, 1) != 0) ? {DOC_W{1'b1}} : {DOC_W{1'b0}};
            end
            default: begin
                return DOC_W'($urandom);
            end
        endcase
    endfunction

    // Small signed values give equal scores; extremes hit the sign boundary.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 3))
            0: begin
                return SCORE_W'(int'($urandom_range(0, 6)) - 3);
            end
            1: begin
                case ($urandom_range(0, 2))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    default: return 32'sh0000_0000;
                endcase
            end
            default: begin
                return SCORE_W'($urandom);
            end
        endcase
    endfunction

    // Present one beat, hold it until taken, then maybe drop valid for a gap.
    // Valid stays high when the next beat follows at once.
    task automatic send(input logic cmd, input logic [DOC_W-1:0] doc,
                        input logic signed [SCORE_W-1:0] score);
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_doc_id   <= doc;
        i_score    <= score;
        do @(posedge i_clk); while (o_in_stall);
        // Inserts under a zero keep count are dropped by the block; don't count them.
        if (cmd == CMD_DRAIN || eff_keep() != 0) begin
            items_sent++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic insert_pair(input logic [DOC_W-1:0] doc,
                               input logic signed [SCORE_W-1:0] score);
        send(CMD_INSERT, doc, score);
    endtask

    // Drain payload fields are don't-care; fill them with noise.
    task automatic drain_store();
        send(CMD_DRAIN, pick_doc(), pick_score());
    endtask

    // Hold the sender until every expected result is in, then let a running
    // replace scan finish.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep(input int value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= KEEP_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_keep = value;
    endtask

    // Result-side stalls: runs of stall and no stall, mostly short, a few long.
    initial begin
        int   run;
        logic hold;
        i_out_stall <= 1'b0;
        forever begin
            hold = !out_calm && ($urandom_range(0, 99) < 35);
            if (hold) begin
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            end else begin
                run = $urandom_range(1, 6);
            end
            i_out_stall <= hold;
            repeat (run) @(posedge i_clk);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int keep_plan [8];
        int phase;
        int batches;
        int kind;
        int n;
        keep_plan  = '{16, 3, 31, 0, 1, 10, 17, 2};
        items_sent = 0;
        cur_keep   = KEEP_RESET;
        in_calm    = 1'b0;
        out_calm   = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_command  <= CMD_INSERT;
        i_doc_id   <= '0;
        i_score    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, keep count 10 from reset.
        // Drain of an empty store: one empty beat.
        drain_store();
        // Field extremes plus an equal-score pair where the smaller id must win.
        insert_pair(31'h0000_0000, 32'sh7FFF_FFFF);
        insert_pair(31'h7FFF_FFFF, 32'sh8000_0000);
        insert_pair(31'd5, 32'sd0);
        insert_pair(31'd3, 32'sd0);
        insert_pair(31'h2AAA_AAAA, -32'sd1);
        insert_pair(31'h5555_5555, 32'sh5555_5555);
        drain_store();

        // Zero keep count: insert is dropped, drain gives the empty beat.
        write_keep(0);
        insert_pair(31'd9, 32'sd100);
        drain_store();

        // Single slot: replace by a better pair, drop an identical one and a worse one.
        write_keep(1);
        insert_pair(31'd4, 32'sd10);
        insert_pair(31'd6, 32'sd20);
        insert_pair(31'd6, 32'sd20);
        insert_pair(31'd1, 32'sd5);
        drain_store();

        // Lower the keep count below the fill level, then replace and drain.
        write_keep(16);
        insert_pair(31'd10, 32'sd1);
        insert_pair(31'd11, 32'sd2);
        insert_pair(31'd12, 32'sd3);
        insert_pair(31'd13, 32'sd4);
        write_keep(2);
        insert_pair(31'd14, 32'sd3);
        drain_store();

        // Random part: phases of one keep count each, mostly fill-then-drain batches.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 8) begin
                write_keep(keep_plan[phase]);
            end else if ($urandom_range(0, 1) != 0) begin
                write_keep($urandom_range(1, 6));
            end else begin
                write_keep($urandom_range(0, 31));
            end
            phase++;
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            batches  = $urandom_range(2, 5);
            repeat (batches) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    // Noise: commands in any order.
                    repeat ($urandom_range(1, 6)) begin
                        send(($urandom_range(0, 9) < 3) ? CMD_DRAIN : CMD_INSERT,
                             pick_doc(), pick_score());
                    end
                end else if (kind == 1) begin
                    // Back-to-back drains: the second one finds the store empty.
                    drain_store();
                    drain_store();
                end else begin
                    // Fill, often past the keep count so replacements happen, then drain.
                    n = $urandom_range(0, 2 * eff_keep() + 2);
                    repeat (n) begin
                        insert_pair(pick_doc(), pick_score());
                    end
                    drain_store();
                end
            end
            // Skip the extra drain about half the time so the next keep count
            // may start on old entries.
            if ($urandom_range(0, 1) != 0) begin
                drain_store();
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== top_k_score_selector_unit.f =====
design/tkss_pkg.sv
design/tkss_ctrl.sv
design/tkss_datapath.sv
design/top_k_score_selector_unit.sv
tb/topk_result_checker.sv
tb/tb_top.sv
